[rtl/lis_pkg.sv]
`default_nettype none

package lis_pkg;

	localparam int VALUE_W          = 16;
	localparam int LENGTH_W         = 6;
	localparam int MAX_ELEMENTS_DEF = 32;
	localparam int VALUE_WIDTH_DEF  = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_TRACE_RD,
		ST_TRACE_WR,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

`default_nettype wire

[rtl/lis_ram.sv]
`default_nettype none

module lis_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/longest_increasing_subsequence.sv]
`default_nettype none

// Longest strictly increasing subsequence, quadratic dynamic programming. Each input
// transaction carries one signed value; a transaction with last set closes the sequence.
// For a value arriving when k elements are already stored, the block reads the k earlier
// entries of the element memory one per cycle, and the input stays busy until that scan
// and the write of the new entry are done; that memory scan is what sets the input rate.
// Values beyond MAX_ELEMENTS are dropped and flag overflow on the results. After the
// closing transaction the chain is traced back one entry per cycle into a reorder buffer,
// then results leave oldest first, each with the total length and last_res on the final
// one; each is read from the buffer and then loaded into the output register once the
// receiver has taken the previous one. The input reopens as soon as the final result
// sits in the output register. No clearing pass is needed after reset.
module longest_increasing_subsequence #(
	parameter int MAX_ELEMENTS = lis_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = lis_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output      logic                                 in_ready,
	input  wire logic signed [lis_pkg::VALUE_W-1:0]   value,
	input  wire logic                                 last,
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	output      logic signed [lis_pkg::VALUE_W-1:0]   value_res,
	output      logic        [lis_pkg::LENGTH_W-1:0]  length,
	output      logic                                 overflow,
	output      logic                                 last_res
);

	import lis_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int IW = $clog2(MAX_ELEMENTS);
	localparam int LW = $clog2(MAX_ELEMENTS + 1);
	localparam int XW = (VW > VALUE_W) ? VW : VALUE_W;
	localparam int DW = IW + LW + VW;

	state_t state_q, state_d;

	logic [LW-1:0]      count_q;
	logic [LW-1:0]      best_q;
	logic [IW-1:0]      best_end_q;
	logic               ovf_q;
	logic               last_q;
	logic [VW-1:0]      new_q;
	logic [IW-1:0]      rd_q;
	logic               scan_vld_s1;
	logic [IW-1:0]      scan_idx_s1;
	logic [LW-1:0]      lmax_q;
	logic [IW-1:0]      pred_q;
	logic [LW-1:0]      k_q;
	logic [IW-1:0]      e_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_res_q;
	logic [LENGTH_W-1:0] length_q;
	logic               overflow_q;
	logic               last_res_q;

	logic               in_acc;
	logic               out_free;
	logic               has_room;
	logic [IW-1:0]      idx;
	logic               issue;
	logic               scan_done;
	logic               smaller;
	logic [LW-1:0]      cand;
	logic [LW-1:0]      new_len;
	logic [LW-1:0]      k_dec;
	logic               emit_last;
	logic               emit_load;
	logic [XW-1:0]      vin_x;
	logic [XW-1:0]      elem_x;
	logic [LW+LENGTH_W-1:0] len_x;

	// element memory: {pred, len, value}
	logic               m_we;
	logic [IW-1:0]      m_waddr;
	logic [DW-1:0]      m_wdata;
	logic               m_re;
	logic [IW-1:0]      m_raddr;
	logic [DW-1:0]      m_rdata;
	logic [VW-1:0]      d_elem;
	logic [LW-1:0]      d_len;
	logic [IW-1:0]      d_path;

	// reorder buffer for the traced chain
	logic               b_we;
	logic [IW-1:0]      b_waddr;
	logic [VALUE_W-1:0] b_wdata;
	logic               b_re;
	logic [IW-1:0]      b_raddr;
	logic [VALUE_W-1:0] b_rdata;

	lis_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	lis_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_order_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	assign d_elem = m_rdata[VW-1:0];
	assign d_len  = m_rdata[VW+LW-1:VW];
	assign d_path = m_rdata[DW-1:VW+LW];

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign has_room  = (count_q < LW'(MAX_ELEMENTS));
	assign idx       = count_q[IW-1:0];
	assign issue     = (state_q == ST_SCAN) && (rd_q < idx);
	assign scan_done = (state_q == ST_SCAN) && !issue && !scan_vld_s1;
	assign smaller   = $signed(d_elem) < $signed(new_q);
	assign cand      = d_len + LW'(1);
	assign new_len   = (lmax_q == '0) ? LW'(1) : lmax_q;
	assign k_dec     = k_q - LW'(1);
	assign emit_last = ((LW'(e_q) + LW'(1)) == best_q);
	assign emit_load = (state_q == ST_EMIT_LD) && out_free;
	assign vin_x     = XW'($unsigned(value));
	assign elem_x    = XW'(d_elem);
	assign len_x     = (LW+LENGTH_W)'(best_q);

	always_comb begin
		state_d = state_q;
		m_we    = 1'b0;
		m_waddr = idx;
		m_wdata = {pred_q, new_len, new_q};
		m_re    = 1'b0;
		m_raddr = '0;
		b_we    = 1'b0;
		b_waddr = k_dec[IW-1:0];
		b_wdata = elem_x[VALUE_W-1:0];
		b_re    = 1'b0;
		b_raddr = e_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (has_room) begin
						state_d = ST_SCAN;
					end else if (last) begin
						state_d = ST_TRACE_RD;
					end
				end
			end
			ST_SCAN: begin
				m_re    = issue;
				m_raddr = rd_q;
				if (scan_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				m_we    = 1'b1;
				state_d = last_q ? ST_TRACE_RD : ST_IDLE;
			end
			ST_TRACE_RD: begin
				m_re    = 1'b1;
				m_raddr = best_end_q;
				state_d = ST_TRACE_WR;
			end
			ST_TRACE_WR: begin
				// follow the predecessor straight from the read data
				b_we    = 1'b1;
				m_re    = (k_q != LW'(1));
				m_raddr = d_path;
				if (k_q == LW'(1)) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				b_re    = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			best_q      <= '0;
			best_end_q  <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			rd_q        <= '0;
			scan_vld_s1 <= 1'b0;
			lmax_q      <= '0;
			pred_q      <= '0;
			k_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				last_q <= last;
				if (has_room) begin
					rd_q        <= '0;
					scan_vld_s1 <= 1'b0;
					lmax_q      <= '0;
					pred_q      <= '0;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_SCAN) begin
				scan_vld_s1 <= issue;
				if (issue) begin
					rd_q <= rd_q + IW'(1);
				end
				// >= keeps the latest position among equal lengths
				if (scan_vld_s1 && smaller && (cand >= lmax_q)) begin
					lmax_q <= cand;
					pred_q <= scan_idx_s1;
				end
			end
			if (state_q == ST_WRITE) begin
				count_q <= count_q + LW'(1);
				if (new_len > best_q) begin
					best_q     <= new_len;
					best_end_q <= idx;
				end
			end
			if (state_q == ST_TRACE_RD) begin
				k_q <= best_q;
			end
			if (state_q == ST_TRACE_WR) begin
				k_q <= k_dec;
				e_q <= '0;
			end
			if (emit_load) begin
				e_q         <= e_q + IW'(1);
				out_valid_q <= 1'b1;
				if (emit_last) begin
					count_q    <= '0;
					best_q     <= '0;
					best_end_q <= '0;
					ovf_q      <= 1'b0;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_q <= vin_x[VW-1:0];
		end
		scan_idx_s1 <= rd_q;
		if (emit_load) begin
			value_res_q <= b_rdata;
			length_q    <= len_x[LENGTH_W-1:0];
			overflow_q  <= ovf_q;
			last_res_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign length    = length_q;
	assign overflow  = overflow_q;
	assign last_res  = last_res_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(MAX_ELEMENTS))
		else $error("element count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == LW'(MAX_ELEMENTS)))
		else $error("overflow set while store not full");

	a_best_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= count_q)
		else $error("best length exceeds element count");

	a_trace_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE_WR) |-> (k_q != '0))
		else $error("trace step with zero remaining");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> (count_q == '0) && (best_q == '0) && out_valid_q)
		else $error("sequence state not cleared after final result");
`endif

endmodule

`default_nettype wire

[dv/tb_longest_increasing_subsequence.sv]
module tb_longest_increasing_subsequence;
	timeunit 1ns;
	timeprecision 1ps;

	import lis_pkg::*;

	localparam int CAPACITY    = 32;
	localparam int TOTAL_ITEMS = 410;
	localparam int HOLD_CYCLES = 600;

	typedef logic signed [VALUE_W-1:0] elem_t;

	typedef struct {
		elem_t               value_res;
		logic [LENGTH_W-1:0] length;
		logic                overflow;
		logic                last_res;
	} subseq_elem_t;

	// Tracks the running sequence and queues the subsequence each closing transaction yields.
	class lis_scoreboard;
		elem_t        elems [CAPACITY];
		int           run_len [CAPACITY];
		int           back_link [CAPACITY];
		int           count;
		int           best_len;
		int           best_pos;
		bit           dropped;
		subseq_elem_t subseq_q[$];
		int           errors;

		function void note_input(elem_t v, logic is_last);
			int len;
			int link;
			int pos;
			subseq_elem_t chain[$];
			subseq_elem_t r;
			if (count < CAPACITY) begin
				len = 1;
				link = 0;
				for (int j = 0; j < count; j++)
					if (elems[j] < v && run_len[j] + 1 > len)
						len = run_len[j] + 1;
				// nearest earlier element that is smaller and one step shorter
				for (int j = count - 1; j >= 0; j--)
					if (elems[j] < v && run_len[j] + 1 == len) begin
						link = j;
						break;
					end
				elems[count] = v;
				run_len[count] = len;
				back_link[count] = link;
				if (len > best_len) begin
					best_len = len;
					best_pos = count;
				end
				count++;
			end else begin
				dropped = 1'b1;
			end
			if (!is_last)
				return;
			pos = best_pos;
			for (int k = 0; k < best_len; k++) begin
				r.value_res = elems[pos];
				r.length = best_len[LENGTH_W-1:0];
				r.overflow = dropped;
				r.last_res = (k == 0);
				chain.push_front(r);
				pos = back_link[pos];
			end
			foreach (chain[i])
				subseq_q.push_back(chain[i]);
			count = 0;
			best_len = 0;
			best_pos = 0;
			dropped = 1'b0;
		endfunction

		function void check_result(subseq_elem_t got);
			subseq_elem_t exp_r;
			if (subseq_q.size() == 0) begin
				$error("unexpected result: value_res %0d length %0d", got.value_res, got.length);
				errors++;
				return;
			end
			exp_r = subseq_q.pop_front();
			if (got.value_res !== exp_r.value_res) begin
				$error("value_res: expected %0d, actual %0d", exp_r.value_res, got.value_res);
				errors++;
			end
			if (got.length !== exp_r.length) begin
				$error("length: expected %0d, actual %0d", exp_r.length, got.length);
				errors++;
			end
			if (got.overflow !== exp_r.overflow) begin
				$error("overflow: expected %0b, actual %0b", exp_r.overflow, got.overflow);
				errors++;
			end
			if (got.last_res !== exp_r.last_res) begin
				$error("last_res: expected %0b, actual %0b", exp_r.last_res, got.last_res);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	elem_t               value = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	elem_t               value_res;
	logic [LENGTH_W-1:0] length;
	logic                overflow;
	logic                last_res;

	lis_scoreboard sb = new();
	int            phase = 0;
	int            items_sent = 0;

	// single values at both extremes, equal values, falling and rising runs,
	// and a case where the nearest shorter predecessor is not the first one
	elem_t dir_v [17] = '{-16'sd32768, 16'sd32767, 5, 5, 5, 3, 2, 1,
		-16'sd32768, 0, 16'sd32767, 1, 3, 2, 4, 0, 5};
	bit dir_last [17] = '{1, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1};

	longest_increasing_subsequence uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_res (value_res),
		.length    (length),
		.overflow  (overflow),
		.last_res  (last_res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(elem_t v, logic is_last);
		int idle_pct;
		idle_pct = (phase == 0) ? 29 : (phase == 1) ? 78 : 0;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(v, is_last);
		items_sent++;
	endtask

	function automatic elem_t pick_value(int style, inout int walk);
		case (style)
			0: return elem_t'($urandom);
			1: return elem_t'(int'($urandom_range(16)) - 8);
			2: begin
				walk += int'($urandom_range(13)) - 3;
				if (walk > 32767)
					walk = -32768 + int'($urandom_range(100));
				return elem_t'(walk);
			end
			3: begin
				case ($urandom_range(5))
					0: return -16'sd32768;
					1: return -16'sd1;
					2: return 16'sd0;
					3: return 16'sd1;
					4: return 16'sd32767;
					default: return elem_t'($urandom);
				endcase
			end
			default: begin
				// strictly rising
				walk += 1 + int'($urandom_range(1500));
				if (walk > 32767)
					walk = 32767;
				return elem_t'(walk);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		subseq_elem_t got;
		if (arst_n && out_valid && out_ready) begin
			got.value_res = value_res;
			got.length = length;
			got.overflow = overflow;
			got.last_res = last_res;
			sb.check_result(got);
		end
	end

	// Receiver: random back-pressure, plus one long hold once traffic is flowing.
	initial begin
		int  hold_left;
		int  taken;
		bit  held;
		int  idle_pct;
		hold_left = 0;
		taken = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			idle_pct = (phase == 0) ? 78 : (phase == 1) ? 29 : 0;
			if (!held && taken >= 40) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		int seq_no;
		int len;
		int style;
		int walk;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_v[i])
			send_item(dir_v[i], dir_last[i]);

		seq_no = 0;
		while (items_sent < TOTAL_ITEMS) begin
			phase = items_sent * 3 / TOTAL_ITEMS;
			if (seq_no == 3) begin
				// one past capacity: the closing transaction itself is dropped
				len = CAPACITY + 1;
				style = 4;
			end else if (seq_no == 12) begin
				len = CAPACITY;
				style = 4;
			end else begin
				len = ($urandom_range(14) == 0) ? int'($urandom_range(40, 30))
					: int'($urandom_range(12, 1));
				style = $urandom_range(4);
			end
			walk = (style == 4) ? -32768 + int'($urandom_range(200))
				: int'($urandom_range(400)) - 200;
			for (int i = 0; i < len; i++)
				send_item(pick_value(style, walk), i == len - 1);
			seq_no++;
		end
		in_valid <= 1'b0;

		while (sb.subseq_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (sb.subseq_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.subseq_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
